[src/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the line pixel stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam logic [7:0] MAX_COL = 8'd128;
    localparam logic [7:0] MAX_ROW = 8'd160;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  x_end;
        logic [7:0]  y_end;
        logic [15:0] pixel_color;
    } in_item_t;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [15:0] pixel_rgb;
        logic        pixel_last;
    } out_item_t;

    // decoded command between front and back
    typedef struct packed {
        op_t                op;
        logic [7:0]         xs;
        logic [7:0]         ys;
        logic [7:0]         xe;
        logic [7:0]         ye;
        logic signed [1:0]  dir_col;
        logic signed [1:0]  dir_row;
        logic [8:0]         twice_dx;
        logic [8:0]         twice_dy;
        logic               x_major;
        logic signed [10:0] err;
        logic [15:0]        color;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_bus_t;

endpackage

[src/lps_front.sv]
// ----------------------------------------------------------------------------
// lps_front
// Classifies each beat and precomputes line setup for start items.
// ----------------------------------------------------------------------------
module lps_front import lps_pkg::*; (
    input  in_item_t item,
    output cmd_t     cmd
);

    logic [7:0]         xs, ys, xe, ye;
    logic signed [8:0]  dx, dy;
    logic [7:0]         adx, ady;
    logic [8:0]         tdx, tdy;
    logic               xmaj;

    always_comb begin
        xs = (item.x_start > MAX_COL) ? MAX_COL : item.x_start;
        ys = (item.y_start > MAX_ROW) ? MAX_ROW : item.y_start;
        xe = (item.x_end   > MAX_COL) ? MAX_COL : item.x_end;
        ye = (item.y_end   > MAX_ROW) ? MAX_ROW : item.y_end;
        dx = $signed({1'b0, xe}) - $signed({1'b0, xs});
        dy = $signed({1'b0, ye}) - $signed({1'b0, ys});
        adx = dx[8] ? 8'(-dx) : dx[7:0];
        ady = dy[8] ? 8'(-dy) : dy[7:0];
        tdx = {adx, 1'b0};
        tdy = {ady, 1'b0};
        xmaj = (tdx >= tdy);

        cmd.op       = item.op;
        cmd.xs       = xs;
        cmd.ys       = ys;
        cmd.xe       = xe;
        cmd.ye       = ye;
        cmd.dir_col  = dx[8] ? -2'sd1 : ((dx != 9'sd0) ? 2'sd1 : 2'sd0);
        cmd.dir_row  = dy[8] ? -2'sd1 : ((dy != 9'sd0) ? 2'sd1 : 2'sd0);
        cmd.twice_dx = tdx;
        cmd.twice_dy = tdy;
        cmd.x_major  = xmaj;
        cmd.err      = xmaj ? ($signed({2'b00, tdy}) - $signed({3'b000, adx}))
                            : ($signed({2'b00, tdx}) - $signed({3'b000, ady}));
        cmd.color    = item.pixel_color;
    end

endmodule

[src/lps_queue.sv]
// ----------------------------------------------------------------------------
// lps_queue
// Two-slot command queue between front and back.
// ----------------------------------------------------------------------------
module lps_queue import lps_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  cmd_t     push_cmd,
    output logic     full,
    input  logic     pop,
    output cmd_bus_t head
);

    logic [1:0] count_reg;
    cmd_t       slot0_reg, slot1_reg;

    assign full = (count_reg == 2'd2);
    assign head = {(count_reg != 2'd0), slot0_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (push && !pop) begin
            count_reg <= count_reg + 2'd1;
        end else if (pop && !push) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && pop) begin
            if (count_reg == 2'd2) begin
                slot0_reg <= slot1_reg;
                slot1_reg <= push_cmd;
            end else begin
                slot0_reg <= push_cmd;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                slot0_reg <= push_cmd;
            end else begin
                slot1_reg <= push_cmd;
            end
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

[src/lps_back.sv]
// ----------------------------------------------------------------------------
// lps_back
// Holds line state, emits one beat per command (start pixel, next pixel, or an
// empty beat when no line is active), registers the result.
module lps_back import lps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_bus_t  head,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [7:0]         cur_col_reg, cur_row_reg, end_col_reg, end_row_reg;
    logic signed [10:0] err_reg;
    logic [8:0]         tdx_reg, tdy_reg;
    logic signed [1:0]  dir_col_reg, dir_row_reg;
    logic               x_major_reg;
    logic [15:0]        color_reg;
    logic               active_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [7:0]         col_next, row_next;
    logic signed [10:0] err_next, major2, minor2;
    logic signed [1:0]  major_dir;
    logic               take_minor, last_next;

    assign pop     = head.valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        major_dir  = x_major_reg ? dir_col_reg : dir_row_reg;
        major2     = $signed({2'b00, x_major_reg ? tdx_reg : tdy_reg});
        minor2     = $signed({2'b00, x_major_reg ? tdy_reg : tdx_reg});
        take_minor = !err_reg[10] && ((err_reg != 11'sd0) || (major_dir == 2'sd1));
        err_next   = err_reg - (take_minor ? major2 : 11'sd0) + minor2;
        col_next   = cur_col_reg;
        row_next   = cur_row_reg;
        if (x_major_reg) begin
            col_next = cur_col_reg + {{6{dir_col_reg[1]}}, dir_col_reg};
            if (take_minor) begin
                row_next = cur_row_reg + {{6{dir_row_reg[1]}}, dir_row_reg};
            end
        end else begin
            row_next = cur_row_reg + {{6{dir_row_reg[1]}}, dir_row_reg};
            if (take_minor) begin
                col_next = cur_col_reg + {{6{dir_col_reg[1]}}, dir_col_reg};
            end
        end
        last_next = x_major_reg ? (col_next == end_col_reg) : (row_next == end_row_reg);
        if (head.cmd.op == OP_START) begin
            col_next  = head.cmd.xs;
            row_next  = head.cmd.ys;
            err_next  = head.cmd.err;
            last_next = head.cmd.x_major ? (head.cmd.xs == head.cmd.xe)
                                         : (head.cmd.ys == head.cmd.ye);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            end_col_reg   <= '0;
            end_row_reg   <= '0;
            err_reg       <= '0;
            tdx_reg       <= '0;
            tdy_reg       <= '0;
            dir_col_reg   <= '0;
            dir_row_reg   <= '0;
            x_major_reg   <= 1'b0;
            color_reg     <= '0;
        end else begin
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (pop) begin
                if (head.cmd.op == OP_START) begin
                    cur_col_reg <= col_next;
                    cur_row_reg <= row_next;
                    end_col_reg <= head.cmd.xe;
                    end_row_reg <= head.cmd.ye;
                    err_reg     <= err_next;
                    tdx_reg     <= head.cmd.twice_dx;
                    tdy_reg     <= head.cmd.twice_dy;
                    dir_col_reg <= head.cmd.dir_col;
                    dir_row_reg <= head.cmd.dir_row;
                    x_major_reg <= head.cmd.x_major;
                    color_reg   <= head.cmd.color;
                    active_reg  <= !last_next;
                end else if (active_reg) begin
                    cur_col_reg <= col_next;
                    cur_row_reg <= row_next;
                    err_reg     <= err_next;
                    active_reg  <= !last_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (head.cmd.op == OP_START) begin
                out_reg <= '{1'b1, col_next, row_next, head.cmd.color, last_next};
            end else if (active_reg) begin
                out_reg <= '{1'b1, col_next, row_next, color_reg, last_next};
            end else begin
                out_reg <= '0;
            end
        end
    end

endmodule

[src/line_pixel_stepper_core.sv]
// ----------------------------------------------------------------------------
// line_pixel_stepper_core
// Bresenham line rasterizer: start beats set up a line, step beats walk it.
// ----------------------------------------------------------------------------
//  channel  ports                      payload     role
//  s_       s_valid s_ready s_data     in_item_t   start / step commands
//  m_       m_valid m_ready m_data     out_item_t  one beat per command
//
//  One beat per cycle sustained while m_ready is high; an s_ beat passes
//  through a command queue slot, then the output register, to m_.
//  Reset is synchronous, active low; it empties the queue and drops any line.
//  With m_ready low the output holds, the queue fills its two slots, then
//  s_ready drops.
// ----------------------------------------------------------------------------
module line_pixel_stepper_core import lps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    cmd_t     front_cmd;
    cmd_bus_t head;
    logic     q_full, pop;

    assign s_ready = !q_full;

    lps_front u_front (
        .item (s_data),
        .cmd  (front_cmd)
    );

    lps_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_valid && s_ready),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    lps_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[src/lps_checker.sv]
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks for the line pixel stepper, bound to the top level.
// ----------------------------------------------------------------------------
module lps_checker import lps_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.pixel_valid |->
            m_data.pixel_x == 8'd0 && m_data.pixel_y == 8'd0 &&
            m_data.pixel_rgb == 16'd0 && !m_data.pixel_last)
        else $error("empty step beat carries data");

    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.pixel_valid |->
            m_data.pixel_x <= MAX_COL && m_data.pixel_y <= MAX_ROW)
        else $error("pixel outside display");

    a_stall_backed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid)
        else $error("input stalled with no result beat pending");

endmodule

bind line_pixel_stepper_core lps_checker u_lps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
